@@ src/ntc_sh_pkg.sv @@
// Shared types and constants of the thermistor converter.
// No dependencies; every other file takes names from here by scope.
package ntc_sh_pkg;

   localparam int CODE_W = 12;
   localparam int RES_W = 16;
   localparam int TEMP_W = 19;
   localparam int STAT_W = 2;
   localparam int COEF_W = 40;
   localparam int FS_W = 16;
   localparam int DATA_W = 64;
   localparam int ADDR_W = 5;
   localparam int REG_LSB = 3;

   // Fixed-point widths of the log and polynomial path.
   localparam int E_W = 4;
   localparam int FR_W = 32;
   localparam int M_W = 32;
   localparam int L_W = E_W + FR_W;
   localparam int L2_W = 40;
   localparam int L3_W = 44;
   localparam int BL_W = 44;
   localparam int CL_W = 52;
   localparam int D_W = 53;
   localparam int CH_W = 18;
   localparam int LN2_W = 28;

   localparam logic [LN2_W-1:0] LN2_Q28 = 28'd186065280;
   localparam logic [TEMP_W-1:0] ABS_ZERO_Q8 = 19'd69926;
   localparam logic [TEMP_W-1:0] K_MAX = 19'd332069;
   localparam logic signed [TEMP_W-1:0] TEMP_MAX = 19'sd262143;
   localparam logic signed [TEMP_W-1:0] TEMP_ABS_ZERO = -19'sd69926;

   localparam logic [RES_W-1:0] PULLUP_RESET = 16'd10000;
   localparam logic [COEF_W-1:0] COEF_A_RESET = 40'd312718699126;
   localparam logic [COEF_W-1:0] COEF_B_RESET = 40'd66987385282;
   localparam logic [COEF_W-1:0] COEF_C_RESET = 40'd18295874;

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_ZERO = 2'd1,
      STATUS_SAT  = 2'd2
   } status_type;

   typedef enum logic [ADDR_W-REG_LSB-1:0] {
      REG_PULLUP = 2'd0,
      REG_COEF_A = 2'd1,
      REG_COEF_B = 2'd2,
      REG_COEF_C = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [RES_W-1:0] pullup_ohms;
      logic [COEF_W-1:0] coef_a;
      logic [COEF_W-1:0] coef_b;
      logic [COEF_W-1:0] coef_c;
   } cfg_type;

   // Per-item side information that rides along the pipeline.
   typedef struct packed {
      logic [RES_W-1:0] resistance;
      status_type status;
      logic zero;
   } side_type;

endpackage

@@ src/ntc_sh_req_if.sv @@
// Input channel of the thermistor converter: one ADC code per item.
// Depends on ntc_sh_pkg for the field width.
interface ntc_sh_req_if;
   logic valid;
   logic ready;
   logic [ntc_sh_pkg::CODE_W-1:0] adc_code;

   modport source (output valid, output adc_code, input ready);
   modport sink (input valid, input adc_code, output ready);
   modport monitor (input valid, input ready, input adc_code);
endinterface

@@ src/ntc_sh_rsp_if.sv @@
// Result channel of the thermistor converter: resistance, temperature, status.
// Depends on ntc_sh_pkg for the field widths.
interface ntc_sh_rsp_if;
   logic valid;
   logic ready;
   logic [ntc_sh_pkg::RES_W-1:0] resistance_ohms;
   logic signed [ntc_sh_pkg::TEMP_W-1:0] temperature_q8;
   logic [ntc_sh_pkg::STAT_W-1:0] status;

   modport source (output valid, output resistance_ohms, output temperature_q8,
                   output status, input ready);
   modport sink (input valid, input resistance_ohms, input temperature_q8,
                 input status, output ready);
   modport monitor (input valid, input ready, input resistance_ohms,
                    input temperature_q8, input status);
endinterface

@@ src/ntc_sh_csr.sv @@
// APB-style register file holding the pull-up value and the three coefficients.
// Depends on ntc_sh_pkg.
module ntc_sh_csr (
   input  logic clock,
   input  logic reset,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [ntc_sh_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [ntc_sh_pkg::DATA_W-1:0] csr_pwdata,
   output logic [ntc_sh_pkg::DATA_W-1:0] csr_prdata,
   output logic csr_pready,
   output ntc_sh_pkg::cfg_type cfg
);
   ntc_sh_pkg::cfg_type cfg_ff, cfg_in;
   ntc_sh_pkg::reg_index_type index;
   logic write;

   assign index = ntc_sh_pkg::reg_index_type'(
      csr_paddr[ntc_sh_pkg::ADDR_W-1:ntc_sh_pkg::REG_LSB]);
   assign write = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         case (index)
            ntc_sh_pkg::REG_PULLUP: cfg_in.pullup_ohms = csr_pwdata[ntc_sh_pkg::RES_W-1:0];
            ntc_sh_pkg::REG_COEF_A: cfg_in.coef_a = csr_pwdata[ntc_sh_pkg::COEF_W-1:0];
            ntc_sh_pkg::REG_COEF_B: cfg_in.coef_b = csr_pwdata[ntc_sh_pkg::COEF_W-1:0];
            ntc_sh_pkg::REG_COEF_C: cfg_in.coef_c = csr_pwdata[ntc_sh_pkg::COEF_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         ntc_sh_pkg::REG_PULLUP: csr_prdata = ntc_sh_pkg::DATA_W'(cfg_ff.pullup_ohms);
         ntc_sh_pkg::REG_COEF_A: csr_prdata = ntc_sh_pkg::DATA_W'(cfg_ff.coef_a);
         ntc_sh_pkg::REG_COEF_B: csr_prdata = ntc_sh_pkg::DATA_W'(cfg_ff.coef_b);
         ntc_sh_pkg::REG_COEF_C: csr_prdata = ntc_sh_pkg::DATA_W'(cfg_ff.coef_c);
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pullup_ohms <= ntc_sh_pkg::PULLUP_RESET;
         cfg_ff.coef_a <= ntc_sh_pkg::COEF_A_RESET;
         cfg_ff.coef_b <= ntc_sh_pkg::COEF_B_RESET;
         cfg_ff.coef_c <= ntc_sh_pkg::COEF_C_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

@@ src/ntc_sh_rdiv.sv @@
// Resistance stage: pull-up times code over the remaining span, one quotient
// bit per pipeline stage, with zero and saturation handling. Uses ntc_sh_pkg.
module ntc_sh_rdiv #(
   parameter int FULL_SCALE = 4095
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  logic [ntc_sh_pkg::CODE_W-1:0] adc_code,
   input  logic [ntc_sh_pkg::RES_W-1:0] pullup_ohms,
   output logic out_valid,
   output ntc_sh_pkg::side_type out_side
);
   localparam int QN = ntc_sh_pkg::RES_W;
   localparam int FS_W = ntc_sh_pkg::FS_W;
   localparam int NUM_W = ntc_sh_pkg::RES_W + ntc_sh_pkg::CODE_W;
   localparam logic [FS_W-1:0] FS = FS_W'(FULL_SCALE);

   logic v0_ff, v0_in;
   logic [ntc_sh_pkg::CODE_W-1:0] code_ff, code_in;
   logic v1_ff, v1_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [FS_W-1:0] den1_ff, den1_in;
   ntc_sh_pkg::status_type st1_ff, st1_in;

   logic dv_ff [0:QN];
   logic dv_in [0:QN];
   logic [FS_W-1:0] rem_ff [0:QN];
   logic [FS_W-1:0] rem_in [0:QN];
   logic [FS_W-1:0] den_ff [0:QN];
   logic [FS_W-1:0] den_in [0:QN];
   logic [QN-1:0] low_ff [0:QN];
   logic [QN-1:0] low_in [0:QN];
   logic [QN-1:0] q_ff [0:QN];
   logic [QN-1:0] q_in [0:QN];
   ntc_sh_pkg::status_type st_ff [0:QN];
   ntc_sh_pkg::status_type st_in [0:QN];

   logic [FS_W:0] t;
   logic [QN-1:0] res;

   always_comb begin
      t = '0;
      v0_in = in_valid;
      code_in = adc_code;
      v1_in = v0_ff;
      num_in = NUM_W'(pullup_ohms) * NUM_W'(code_ff);
      den1_in = FS - FS_W'(code_ff);
      if (code_ff == '0) begin
         st1_in = ntc_sh_pkg::STATUS_ZERO;
      end else if (FS_W'(code_ff) >= FS) begin
         st1_in = ntc_sh_pkg::STATUS_SAT;
      end else begin
         st1_in = ntc_sh_pkg::STATUS_OK;
      end

      // A quotient of 2^16 or more shows as a high part already at or above the divisor.
      dv_in[0] = v1_ff;
      rem_in[0] = FS_W'(num_ff[NUM_W-1:QN]);
      low_in[0] = num_ff[QN-1:0];
      q_in[0] = '0;
      den_in[0] = den1_ff;
      if (st1_ff == ntc_sh_pkg::STATUS_OK && FS_W'(num_ff[NUM_W-1:QN]) >= den1_ff) begin
         st_in[0] = ntc_sh_pkg::STATUS_SAT;
      end else begin
         st_in[0] = st1_ff;
      end

      for (int k = 1; k <= QN; k++) begin
         t = {rem_ff[k-1], low_ff[k-1][QN-1]};
         dv_in[k] = dv_ff[k-1];
         den_in[k] = den_ff[k-1];
         st_in[k] = st_ff[k-1];
         low_in[k] = low_ff[k-1] << 1;
         if (t >= {1'b0, den_ff[k-1]}) begin
            rem_in[k] = FS_W'(t - {1'b0, den_ff[k-1]});
            q_in[k] = {q_ff[k-1][QN-2:0], 1'b1};
         end else begin
            rem_in[k] = FS_W'(t);
            q_in[k] = {q_ff[k-1][QN-2:0], 1'b0};
         end
      end
   end

   assign res = (st_ff[QN] == ntc_sh_pkg::STATUS_SAT) ? '1 : q_ff[QN];
   assign out_valid = dv_ff[QN];
   assign out_side.resistance = res;
   assign out_side.status = st_ff[QN];
   assign out_side.zero = (res == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         for (int k = 0; k <= QN; k++) dv_ff[k] <= 1'b0;
      end else if (en) begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         for (int k = 0; k <= QN; k++) dv_ff[k] <= dv_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         code_ff <= code_in;
         num_ff <= num_in;
         den1_ff <= den1_in;
         st1_ff <= st1_in;
         for (int k = 0; k <= QN; k++) begin
            rem_ff[k] <= rem_in[k];
            den_ff[k] <= den_in[k];
            low_ff[k] <= low_in[k];
            q_ff[k] <= q_in[k];
            st_ff[k] <= st_in[k];
         end
      end
   end
endmodule

@@ src/ntc_sh_log.sv @@
// Natural log of the resistance in Q32: normalize, one squaring per stage for
// each fraction bit of log2, then a two-stage multiply by ln 2. Uses ntc_sh_pkg.
module ntc_sh_log (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  ntc_sh_pkg::side_type in_side,
   output logic out_valid,
   output ntc_sh_pkg::side_type out_side,
   output logic [ntc_sh_pkg::L_W-1:0] out_ln
);
   localparam int RES_W = ntc_sh_pkg::RES_W;
   localparam int E_W = ntc_sh_pkg::E_W;
   localparam int FR_W = ntc_sh_pkg::FR_W;
   localparam int M_W = ntc_sh_pkg::M_W;
   localparam int L_W = ntc_sh_pkg::L_W;
   localparam int CH_W = ntc_sh_pkg::CH_W;
   localparam int LN2_W = ntc_sh_pkg::LN2_W;
   localparam int PA_W = CH_W + LN2_W;
   localparam int ACC_W = L_W + LN2_W;

   logic v_ff [0:FR_W];
   logic v_in [0:FR_W];
   logic [M_W-1:0] m_ff [0:FR_W];
   logic [M_W-1:0] m_in [0:FR_W];
   logic [FR_W-1:0] fr_ff [0:FR_W];
   logic [FR_W-1:0] fr_in [0:FR_W];
   logic [E_W-1:0] e_ff [0:FR_W];
   logic [E_W-1:0] e_in [0:FR_W];
   ntc_sh_pkg::side_type side_ff [0:FR_W];
   ntc_sh_pkg::side_type side_in [0:FR_W];

   logic va_ff, va_in, vb_ff, vb_in;
   logic [PA_W-1:0] pa_ff, pa_in;
   logic [L_W-CH_W-1:0] lghi_ff, lghi_in;
   ntc_sh_pkg::side_type sa_ff, sa_in, sb_ff, sb_in;
   logic [L_W-1:0] l_ff, l_in;

   logic [E_W-1:0] e_n;
   logic [RES_W-1:0] r_sh;
   logic [2*M_W-1:0] sq;
   logic [M_W:0] t;
   logic [L_W-1:0] lg;
   logic [ACC_W-1:0] acc;

   always_comb begin
      e_n = '0;
      sq = '0;
      t = '0;
      for (int i = 0; i < RES_W; i++) begin
         if (in_side.resistance[i]) e_n = E_W'(i);
      end
      r_sh = in_side.resistance << (E_W'(RES_W - 1) - e_n);
      v_in[0] = in_valid;
      m_in[0] = {r_sh, {(M_W-RES_W){1'b0}}};
      fr_in[0] = '0;
      e_in[0] = e_n;
      side_in[0] = in_side;

      // Squaring the Q31 mantissa doubles log2; an overflow past 2 is the next bit.
      for (int k = 1; k <= FR_W; k++) begin
         sq = (2*M_W)'(m_ff[k-1]) * (2*M_W)'(m_ff[k-1]);
         t = sq[2*M_W-1:M_W-1];
         v_in[k] = v_ff[k-1];
         e_in[k] = e_ff[k-1];
         side_in[k] = side_ff[k-1];
         fr_in[k] = {fr_ff[k-1][FR_W-2:0], t[M_W]};
         m_in[k] = t[M_W] ? t[M_W:1] : t[M_W-1:0];
      end

      lg = {e_ff[FR_W], fr_ff[FR_W]};
      va_in = v_ff[FR_W];
      sa_in = side_ff[FR_W];
      pa_in = PA_W'(lg[CH_W-1:0]) * PA_W'(ntc_sh_pkg::LN2_Q28);
      lghi_in = lg[L_W-1:CH_W];

      acc = ACC_W'(pa_ff) + ((ACC_W'(lghi_ff) * ACC_W'(ntc_sh_pkg::LN2_Q28)) << CH_W);
      vb_in = va_ff;
      sb_in = sa_ff;
      l_in = acc[ACC_W-1:LN2_W];
   end

   assign out_valid = vb_ff;
   assign out_side = sb_ff;
   assign out_ln = l_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= FR_W; k++) v_ff[k] <= 1'b0;
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (en) begin
         for (int k = 0; k <= FR_W; k++) v_ff[k] <= v_in[k];
         va_ff <= va_in;
         vb_ff <= vb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= FR_W; k++) begin
            m_ff[k] <= m_in[k];
            fr_ff[k] <= fr_in[k];
            e_ff[k] <= e_in[k];
            side_ff[k] <= side_in[k];
         end
         pa_ff <= pa_in;
         lghi_ff <= lghi_in;
         sa_ff <= sa_in;
         sb_ff <= sb_in;
         l_ff <= l_in;
      end
   end
endmodule

@@ src/ntc_sh_poly.sv @@
// Steinhart-Hart denominator A + B*L + C*L^3 in Q48, built from 18-bit partial
// products, one per multiplier and stage. Uses ntc_sh_pkg.
module ntc_sh_poly (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  ntc_sh_pkg::cfg_type cfg,
   input  logic in_valid,
   input  ntc_sh_pkg::side_type in_side,
   input  logic [ntc_sh_pkg::L_W-1:0] in_ln,
   output logic out_valid,
   output ntc_sh_pkg::side_type out_side,
   output logic [ntc_sh_pkg::D_W-1:0] out_den
);
   localparam int L_W = ntc_sh_pkg::L_W;
   localparam int L2_W = ntc_sh_pkg::L2_W;
   localparam int L3_W = ntc_sh_pkg::L3_W;
   localparam int BL_W = ntc_sh_pkg::BL_W;
   localparam int CL_W = ntc_sh_pkg::CL_W;
   localparam int D_W = ntc_sh_pkg::D_W;
   localparam int CH = ntc_sh_pkg::CH_W;
   localparam int CW = ntc_sh_pkg::COEF_W;
   localparam int SH = 32;
   localparam int LL_W = 2 * L_W;
   localparam int B_W = CW + L_W;
   localparam int L3F_W = L2_W + L_W;
   localparam int C_W = CW + L3_W;
   localparam int P1A_W = L_W + CH;
   localparam int P1B_W = CW + CH;
   localparam int P3_W = L2_W + CH;
   localparam int P5_W = CW + CH;
   localparam int P6_W = CW + 2 * CH;

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in;
   logic v5_ff, v5_in, v6_ff, v6_in, v7_ff, v7_in, v8_ff, v8_in;
   ntc_sh_pkg::side_type s1_ff, s1_in, s2_ff, s2_in, s3_ff, s3_in, s4_ff, s4_in;
   ntc_sh_pkg::side_type s5_ff, s5_in, s6_ff, s6_in, s7_ff, s7_in, s8_ff, s8_in;

   logic [L_W-1:0] l1_ff, l1_in, l2l_ff, l2l_in;
   logic [P1A_W-1:0] llp_ff, llp_in;
   logic [P1B_W-1:0] blp_ff, blp_in;
   logic [L2_W-1:0] l2_ff, l2_in;
   logic [BL_W-1:0] bl2_ff, bl2_in, bl3_ff, bl3_in, bl4_ff, bl4_in;
   logic [BL_W-1:0] bl5_ff, bl5_in, bl6_ff, bl6_in, bl7_ff, bl7_in;
   logic [L_W-CH-1:0] lhi3_ff, lhi3_in;
   logic [L2_W-1:0] l23_ff, l23_in;
   logic [P3_W-1:0] p3_ff, p3_in;
   logic [L3_W-1:0] l3_ff, l3_in;
   logic [L3_W-CH-1:0] l3hi5_ff, l3hi5_in;
   logic [P5_W-1:0] p5_ff, p5_in;
   logic [L3_W-2*CH-1:0] l3top6_ff, l3top6_in;
   logic [P6_W-1:0] p6_ff, p6_in;
   logic [CL_W-1:0] cl7_ff, cl7_in;
   logic [D_W-1:0] d8_ff, d8_in;

   logic [LL_W-1:0] llf;
   logic [B_W-1:0] blf;
   logic [L3F_W-1:0] l3f;
   logic [C_W-1:0] clf;

   always_comb begin
      // L*L and B*L, low chunk of L.
      v1_in = in_valid;
      s1_in = in_side;
      l1_in = in_ln;
      llp_in = P1A_W'(in_ln) * P1A_W'(in_ln[CH-1:0]);
      blp_in = P1B_W'(cfg.coef_b) * P1B_W'(in_ln[CH-1:0]);

      // High chunk of L completes L^2 and B*L.
      llf = LL_W'(llp_ff) + ((LL_W'(l1_ff) * LL_W'(l1_ff[L_W-1:CH])) << CH);
      blf = B_W'(blp_ff) + ((B_W'(cfg.coef_b) * B_W'(l1_ff[L_W-1:CH])) << CH);
      v2_in = v1_ff;
      s2_in = s1_ff;
      l2l_in = l1_ff;
      l2_in = llf[SH+L2_W-1:SH];
      bl2_in = blf[SH+BL_W-1:SH];

      // L^2 * L, low chunk.
      v3_in = v2_ff;
      s3_in = s2_ff;
      bl3_in = bl2_ff;
      lhi3_in = l2l_ff[L_W-1:CH];
      l23_in = l2_ff;
      p3_in = P3_W'(l2_ff) * P3_W'(l2l_ff[CH-1:0]);

      // L^2 * L, high chunk.
      l3f = L3F_W'(p3_ff) + ((L3F_W'(l23_ff) * L3F_W'(lhi3_ff)) << CH);
      v4_in = v3_ff;
      s4_in = s3_ff;
      bl4_in = bl3_ff;
      l3_in = l3f[SH+L3_W-1:SH];

      // C * L^3 over three chunks.
      v5_in = v4_ff;
      s5_in = s4_ff;
      bl5_in = bl4_ff;
      l3hi5_in = l3_ff[L3_W-1:CH];
      p5_in = P5_W'(cfg.coef_c) * P5_W'(l3_ff[CH-1:0]);

      v6_in = v5_ff;
      s6_in = s5_ff;
      bl6_in = bl5_ff;
      l3top6_in = l3hi5_ff[L3_W-CH-1:CH];
      p6_in = P6_W'(p5_ff) + ((P6_W'(cfg.coef_c) * P6_W'(l3hi5_ff[CH-1:0])) << CH);

      clf = C_W'(p6_ff) + ((C_W'(cfg.coef_c) * C_W'(l3top6_ff)) << (2 * CH));
      v7_in = v6_ff;
      s7_in = s6_ff;
      bl7_in = bl6_ff;
      cl7_in = clf[SH+CL_W-1:SH];

      v8_in = v7_ff;
      s8_in = s7_ff;
      d8_in = D_W'(cfg.coef_a) + D_W'(bl7_ff) + D_W'(cl7_ff);
   end

   assign out_valid = v8_ff;
   assign out_side = s8_ff;
   assign out_den = d8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
         v6_ff <= v6_in;
         v7_ff <= v7_in;
         v8_ff <= v8_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
         s7_ff <= s7_in;
         s8_ff <= s8_in;
         l1_ff <= l1_in;
         llp_ff <= llp_in;
         blp_ff <= blp_in;
         l2l_ff <= l2l_in;
         l2_ff <= l2_in;
         bl2_ff <= bl2_in;
         bl3_ff <= bl3_in;
         bl4_ff <= bl4_in;
         bl5_ff <= bl5_in;
         bl6_ff <= bl6_in;
         bl7_ff <= bl7_in;
         lhi3_ff <= lhi3_in;
         l23_ff <= l23_in;
         p3_ff <= p3_in;
         l3_ff <= l3_in;
         l3hi5_ff <= l3hi5_in;
         p5_ff <= p5_in;
         l3top6_ff <= l3top6_in;
         p6_ff <= p6_in;
         cl7_ff <= cl7_in;
         d8_ff <= d8_in;
      end
   end
endmodule

@@ src/ntc_sh_recip.sv @@
// Rounded reciprocal of the denominator in Kelvin Q8, one quotient bit per
// stage, then the offset to Celsius and saturation. Uses ntc_sh_pkg.
module ntc_sh_recip (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  ntc_sh_pkg::side_type in_side,
   input  logic [ntc_sh_pkg::D_W-1:0] in_den,
   output logic out_valid,
   output logic [ntc_sh_pkg::RES_W-1:0] out_resistance,
   output logic signed [ntc_sh_pkg::TEMP_W-1:0] out_temperature,
   output logic [ntc_sh_pkg::STAT_W-1:0] out_status
);
   localparam int D_W = ntc_sh_pkg::D_W;
   localparam int QK = ntc_sh_pkg::TEMP_W;
   localparam int N_W = 57;
   localparam int TEMP_W = ntc_sh_pkg::TEMP_W;

   logic v_ff [0:QK];
   logic v_in [0:QK];
   logic [D_W-1:0] rem_ff [0:QK];
   logic [D_W-1:0] rem_in [0:QK];
   logic [D_W-1:0] d_ff [0:QK];
   logic [D_W-1:0] d_in [0:QK];
   logic [QK-1:0] low_ff [0:QK];
   logic [QK-1:0] low_in [0:QK];
   logic [QK-1:0] q_ff [0:QK];
   logic [QK-1:0] q_in [0:QK];
   logic ovf_ff [0:QK];
   logic ovf_in [0:QK];
   ntc_sh_pkg::side_type side_ff [0:QK];
   ntc_sh_pkg::side_type side_in [0:QK];

   logic ov_ff, ov_in;
   logic [ntc_sh_pkg::RES_W-1:0] res_ff, res_in;
   logic signed [TEMP_W-1:0] temp_ff, temp_in;
   logic [ntc_sh_pkg::STAT_W-1:0] stat_ff, stat_in;

   logic [N_W-1:0] n;
   logic [D_W:0] t;

   always_comb begin
      t = '0;
      // Numerator 2^56 + D/2; a quotient past 19 bits, or a zero divisor, is saturation.
      n = (N_W'(1) << (N_W - 1)) + N_W'(in_den >> 1);
      v_in[0] = in_valid;
      side_in[0] = in_side;
      d_in[0] = in_den;
      rem_in[0] = D_W'(n[N_W-1:QK]);
      low_in[0] = n[QK-1:0];
      q_in[0] = '0;
      ovf_in[0] = (D_W'(n[N_W-1:QK]) >= in_den);

      for (int k = 1; k <= QK; k++) begin
         t = {rem_ff[k-1], low_ff[k-1][QK-1]};
         v_in[k] = v_ff[k-1];
         side_in[k] = side_ff[k-1];
         d_in[k] = d_ff[k-1];
         ovf_in[k] = ovf_ff[k-1];
         low_in[k] = low_ff[k-1] << 1;
         if (t >= {1'b0, d_ff[k-1]}) begin
            rem_in[k] = D_W'(t - {1'b0, d_ff[k-1]});
            q_in[k] = {q_ff[k-1][QK-2:0], 1'b1};
         end else begin
            rem_in[k] = D_W'(t);
            q_in[k] = {q_ff[k-1][QK-2:0], 1'b0};
         end
      end

      ov_in = v_ff[QK];
      res_in = side_ff[QK].resistance;
      stat_in = side_ff[QK].status;
      if (side_ff[QK].zero) begin
         temp_in = ntc_sh_pkg::TEMP_ABS_ZERO;
      end else if (ovf_ff[QK] || q_ff[QK] > ntc_sh_pkg::K_MAX) begin
         temp_in = ntc_sh_pkg::TEMP_MAX;
      end else begin
         temp_in = signed'(TEMP_W'(q_ff[QK] - ntc_sh_pkg::ABS_ZERO_Q8));
      end
   end

   assign out_valid = ov_ff;
   assign out_resistance = res_ff;
   assign out_temperature = temp_ff;
   assign out_status = stat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QK; k++) v_ff[k] <= 1'b0;
         ov_ff <= 1'b0;
      end else if (en) begin
         for (int k = 0; k <= QK; k++) v_ff[k] <= v_in[k];
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= QK; k++) begin
            rem_ff[k] <= rem_in[k];
            d_ff[k] <= d_in[k];
            low_ff[k] <= low_in[k];
            q_ff[k] <= q_in[k];
            ovf_ff[k] <= ovf_in[k];
            side_ff[k] <= side_in[k];
         end
         res_ff <= res_in;
         temp_ff <= temp_in;
         stat_ff <= stat_in;
      end
   end
endmodule

@@ src/ntc_steinhart_hart_converter.sv @@
// Top level of the NTC thermistor converter: register file and the four pipeline sections.
// Depends on ntc_sh_pkg, both channel interfaces and the ntc_sh_* section modules.

// The converter takes one ADC code per cycle while the pipeline advances and returns
// the thermistor resistance in whole ohms, the Steinhart-Hart temperature in 1/256 degC
// and a status code. Most stages lie in the bit-serial dividers (16 stages for the
// resistance, 19 for the reciprocal) and the 32 squaring stages of the logarithm;
// every stage holds one item, so a new item is taken whenever the pipeline advances. The
// whole pipeline advances together: it moves whenever the output register is empty or its
// item is being taken, and holds in place otherwise, so no item is lost or repeated.
// Register writes go through the APB-style port at byte addresses 0, 8, 16 and 24
// and must be made while no item is in flight.
module ntc_steinhart_hart_converter #(
   parameter int ADC_FULL_SCALE = 4095
) (
   input  logic clock,
   input  logic reset,
   ntc_sh_req_if.sink req_chan,
   ntc_sh_rsp_if.source rsp_chan,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [ntc_sh_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [ntc_sh_pkg::DATA_W-1:0] csr_pwdata,
   output logic [ntc_sh_pkg::DATA_W-1:0] csr_prdata,
   output logic csr_pready
);
   ntc_sh_pkg::cfg_type cfg;
   logic en;

   logic rd_valid, lg_valid, pl_valid;
   ntc_sh_pkg::side_type rd_side, lg_side, pl_side;
   logic [ntc_sh_pkg::L_W-1:0] lg_ln;
   logic [ntc_sh_pkg::D_W-1:0] pl_den;

   // The pipeline moves as one; an item is taken whenever it moves.
   assign en = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = en;

   ntc_sh_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .cfg(cfg)
   );

   // Resistance from the divider, with zero-code and saturation status.
   ntc_sh_rdiv #(.FULL_SCALE(ADC_FULL_SCALE)) u_rdiv (
      .clock(clock),
      .reset(reset),
      .en(en),
      .in_valid(req_chan.valid),
      .adc_code(req_chan.adc_code),
      .pullup_ohms(cfg.pullup_ohms),
      .out_valid(rd_valid),
      .out_side(rd_side)
   );

   // Natural log of the (possibly saturated) resistance.
   ntc_sh_log u_log (
      .clock(clock),
      .reset(reset),
      .en(en),
      .in_valid(rd_valid),
      .in_side(rd_side),
      .out_valid(lg_valid),
      .out_side(lg_side),
      .out_ln(lg_ln)
   );

   // Denominator of the Steinhart-Hart equation.
   ntc_sh_poly u_poly (
      .clock(clock),
      .reset(reset),
      .en(en),
      .cfg(cfg),
      .in_valid(lg_valid),
      .in_side(lg_side),
      .in_ln(lg_ln),
      .out_valid(pl_valid),
      .out_side(pl_side),
      .out_den(pl_den)
   );

   // Reciprocal, Celsius offset, saturation and the output register.
   ntc_sh_recip u_recip (
      .clock(clock),
      .reset(reset),
      .en(en),
      .in_valid(pl_valid),
      .in_side(pl_side),
      .in_den(pl_den),
      .out_valid(rsp_chan.valid),
      .out_resistance(rsp_chan.resistance_ohms),
      .out_temperature(rsp_chan.temperature_q8),
      .out_status(rsp_chan.status)
   );
endmodule

@@ src/ntc_sh_check.sv @@
// Port-level checks of the thermistor converter, bound to its top level.
// Depends on ntc_sh_pkg; watches the channel signals of the top level.
module ntc_sh_check (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [ntc_sh_pkg::RES_W-1:0] rsp_resistance_ohms,
   input logic signed [ntc_sh_pkg::TEMP_W-1:0] rsp_temperature_q8,
   input logic [ntc_sh_pkg::STAT_W-1:0] rsp_status
);
   // A result that is not taken stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable(rsp_resistance_ohms) && $stable(rsp_temperature_q8)
         && $stable(rsp_status))
      else $error("result item changed while stalled");

   // Input is held off only while a result waits.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input held off without a stalled result");

   // Zero resistance always reads as absolute zero.
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_resistance_ohms == '0
         |-> rsp_temperature_q8 == ntc_sh_pkg::TEMP_ABS_ZERO)
      else $error("zero resistance with wrong temperature");

   // A saturated item carries the full-scale resistance.
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ntc_sh_pkg::STATUS_SAT
         |-> rsp_resistance_ohms == '1)
      else $error("saturated item without full-scale resistance");

   // The pipeline is empty after reset.
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result item valid after reset");
endmodule

bind ntc_steinhart_hart_converter ntc_sh_check u_check (
   .clock(clock),
   .reset(reset),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_resistance_ohms(rsp_chan.resistance_ohms),
   .rsp_temperature_q8(rsp_chan.temperature_q8),
   .rsp_status(rsp_chan.status)
);
